### sv/bcg_pkg.sv
`timescale 1ns / 1ps

package bcg_pkg;

    // Default coordinate width
    localparam int COORD_BITS_DEF = 12;

    // Operation codes
    localparam logic [1:0] FUNC_COPY   = 2'd0;
    localparam logic [1:0] FUNC_FILL   = 2'd1;
    localparam logic [1:0] FUNC_INVERT = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_FRAME_BASE  = 2'd0;
    localparam logic [1:0] CFG_ROW_PITCH   = 2'd1;
    localparam logic [1:0] CFG_PIXEL_DEPTH = 2'd2;

    localparam logic [5:0] DEPTH_RESET = 6'd8;
    localparam logic [5:0] DEPTH_16BPP = 6'd16;

    // Engine register offsets
    localparam logic [15:0] OFS_SRC_ADDR = 16'h8280;
    localparam logic [15:0] OFS_DST_ADDR = 16'h8284;
    localparam logic [15:0] OFS_PITCH    = 16'h8288;
    localparam logic [15:0] OFS_SIZE     = 16'h828c;
    localparam logic [15:0] OFS_FG       = 16'h8290;
    localparam logic [15:0] OFS_BG       = 16'h8294;
    localparam logic [15:0] OFS_TOKEN_LO = 16'h8298;
    localparam logic [15:0] OFS_TOKEN_HI = 16'h829c;
    localparam logic [15:0] OFS_CMD      = 16'h82aa;

    // Raster op data words
    localparam logic [31:0] ROP_COPY   = 32'hcc000000;
    localparam logic [31:0] ROP_FILL   = 32'h0c000000;
    localparam logic [31:0] ROP_INVERT = 32'h03000000;

    // Command words
    localparam logic [15:0] CMD_COPY_BACK = 16'h0002;
    localparam logic [15:0] CMD_FWD_BITS  = 16'h0030;
    localparam logic [15:0] CMD_FILL      = 16'h0031;
    localparam logic [15:0] CMD_INVERT    = 16'h0032;

    // Write slots within one primitive
    localparam int          SLOT_W        = 4;
    localparam logic [3:0]  SLOT_SRC      = 4'd0;
    localparam logic [3:0]  SLOT_DST      = 4'd1;
    localparam logic [3:0]  SLOT_PITCH    = 4'd2;
    localparam logic [3:0]  SLOT_SIZE     = 4'd3;
    localparam logic [3:0]  SLOT_FG       = 4'd4;
    localparam logic [3:0]  SLOT_BG       = 4'd5;
    localparam logic [3:0]  SLOT_CMD      = 4'd6;
    localparam logic [3:0]  SLOT_TOKEN_LO = 4'd7;
    localparam logic [3:0]  SLOT_TOKEN_HI = 4'd8;

    typedef struct packed {
        logic [31:0] base;
        logic [15:0] pitch;
        logic [5:0]  depth;
    } cfg_t;

    // Primitive after the multiply stage
    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] src_xb;
        logic [31:0] src_yb;
        logic [31:0] dst_xb;
        logic [31:0] dst_yb;
        logic [31:0] h_pitch;
        logic [15:0] width_f;
        logic [15:0] height_f;
        logic [15:0] color;
        logic        first;
        logic        last;
    } prim_t;

    function automatic logic [15:0] slot_offset(input logic [3:0] slot);
        logic [15:0] ofs;
        unique case (slot)
            SLOT_SRC:      ofs = OFS_SRC_ADDR;
            SLOT_DST:      ofs = OFS_DST_ADDR;
            SLOT_PITCH:    ofs = OFS_PITCH;
            SLOT_SIZE:     ofs = OFS_SIZE;
            SLOT_FG:       ofs = OFS_FG;
            SLOT_BG:       ofs = OFS_BG;
            SLOT_CMD:      ofs = OFS_CMD;
            SLOT_TOKEN_LO: ofs = OFS_TOKEN_LO;
            SLOT_TOKEN_HI: ofs = OFS_TOKEN_HI;
            default:       ofs = OFS_CMD;
        endcase
        return ofs;
    endfunction

endpackage

### sv/blit_command_generator.sv
`timescale 1ns / 1ps
// From input accept, items pass the input, multiply, sequencer and output registers.
// Throughput: 7 writes per primitive, 9 with the batch sync token, one write
//   per cycle while m_axis_tready allows; the next primitive is taken while the
//   current one drains, and one primitive at a time holds the single write port.
// Reset: synchronous, active low; empties all stages, clears the issued
//   counter and returns frame_base, row_pitch to 0 and pixel_depth to 8.

module blit_command_generator import bcg_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int S_TDATA_W = ((18 + 6 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // Configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,

    // Primitive items
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata, low bit up: func, src_x, src_y, dst_x, dst_y, rect_width,
    //   rect_height, fill_color, zero pad
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tuser,   // first_in_batch
    input  logic                 s_axis_tlast,   // last_in_batch

    // Register write items
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [47:0]          m_axis_tdata,   // reg_offset[15:0], reg_data[47:16]
    output logic                 m_axis_tlast    // last_write
);

    // ---------------------------------------------------------------
    // Configuration registers, always ready. Write only while idle; not enforced.
    // ---------------------------------------------------------------
    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.base  <= '0;
            cfg_reg.pitch <= '0;
            cfg_reg.depth <= DEPTH_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FRAME_BASE:  cfg_reg.base  <= cfg_data;
                CFG_ROW_PITCH:   cfg_reg.pitch <= cfg_data[15:0];
                CFG_PIXEL_DEPTH: cfg_reg.depth <= cfg_data[5:0];
                default: ;  // no register there
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Front: input register and multiply stage
    // ---------------------------------------------------------------
    logic  fr_valid;
    logic  fr_ready;
    prim_t fr_prim;

    bcg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .in_first  (s_axis_tuser),
        .in_last   (s_axis_tlast),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_prim  (fr_prim)
    );

    // ---------------------------------------------------------------
    // Sequencer stage: holds one primitive with its addresses summed,
    // steps through its write slots.
    // ---------------------------------------------------------------
    logic              v3_reg;
    logic [1:0]        func3_reg;
    logic [31:0]       src3_reg, dst3_reg, adj3_reg, size3_reg;
    logic [15:0]       color3_reg;
    logic              last3_reg;
    logic [63:0]       token3_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic [63:0]       issued_reg;
    logic [63:0]       issued_next;

    logic              load3;       // front item consumed this cycle
    logic              load_valid;  // ... and it is a real operation
    logic              seq_fire;    // a write moves into the output register
    logic              seq_final;   // ... and it is the primitive's last

    logic              fwd;
    logic [31:0]       src_back, dst_back;
    logic [31:0]       wr_data;
    logic              wr_last;

    logic              mv_reg;
    logic [47:0]       mdata_reg;
    logic              mlast_reg;

    assign seq_fire  = v3_reg && (!mv_reg || m_axis_tready);
    assign wr_last   = (slot_reg == SLOT_CMD && !last3_reg) || (slot_reg == SLOT_TOKEN_HI);
    assign seq_final = seq_fire && wr_last;

    assign fr_ready   = !v3_reg || seq_final;
    assign load3      = fr_valid && fr_ready;
    // The unused operation code is dropped here: no writes, no counter bump.
    assign load_valid = load3 && (fr_prim.func == FUNC_COPY || fr_prim.func == FUNC_FILL ||
                                  fr_prim.func == FUNC_INVERT);

    assign issued_next = issued_reg + 64'(fr_prim.first);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg     <= 1'b0;
            slot_reg   <= '0;
            issued_reg <= '0;
        end else begin
            if (load3) begin
                v3_reg   <= load_valid;
                slot_reg <= SLOT_SRC;
            end else if (seq_final) begin
                v3_reg <= 1'b0;
            end else if (seq_fire) begin
                slot_reg <= slot_reg + SLOT_W'(1);
            end
            if (load_valid) begin
                issued_reg <= issued_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_valid) begin
            func3_reg  <= fr_prim.func;
            src3_reg   <= cfg_reg.base + fr_prim.src_xb + fr_prim.src_yb;
            dst3_reg   <= cfg_reg.base + fr_prim.dst_xb + fr_prim.dst_yb;
            adj3_reg   <= 32'(fr_prim.width_f) + fr_prim.h_pitch;
            size3_reg  <= {fr_prim.height_f, fr_prim.width_f};
            color3_reg <= fr_prim.color;
            last3_reg  <= fr_prim.last;
            token3_reg <= issued_next;
        end
    end

    // Copy runs forward when the source address is greater than the destination; otherwise both
    // addresses move to the far corner.
    assign fwd      = src3_reg > dst3_reg;
    assign src_back = src3_reg + adj3_reg;
    assign dst_back = dst3_reg + adj3_reg;

    always_comb begin
        wr_data = '0;
        unique case (slot_reg)
            SLOT_SRC: begin
                priority case (func3_reg)
                    FUNC_COPY: wr_data = fwd ? src3_reg : src_back;
                    FUNC_FILL: wr_data = '0;
                    default:   wr_data = dst3_reg;
                endcase
            end
            SLOT_DST: begin
                if (func3_reg == FUNC_COPY) begin
                    wr_data = fwd ? dst3_reg : dst_back;
                end else begin
                    wr_data = dst3_reg;
                end
            end
            SLOT_PITCH: begin
                if (func3_reg == FUNC_FILL) begin
                    wr_data = {cfg_reg.pitch, 16'h0000};
                end else begin
                    wr_data = {cfg_reg.pitch, cfg_reg.pitch};
                end
            end
            SLOT_SIZE: wr_data = size3_reg;
            SLOT_FG: begin
                priority case (func3_reg)
                    FUNC_COPY: wr_data = ROP_COPY;
                    FUNC_FILL: wr_data = ROP_FILL | 32'(color3_reg);
                    default:   wr_data = ROP_INVERT;
                endcase
            end
            SLOT_BG: begin
                priority case (func3_reg)
                    FUNC_COPY: wr_data = ROP_COPY;
                    FUNC_FILL: wr_data = ROP_FILL;
                    default:   wr_data = ROP_INVERT;
                endcase
            end
            SLOT_CMD: begin
                priority case (func3_reg)
                    FUNC_COPY: wr_data = 32'(fwd ? (CMD_COPY_BACK | CMD_FWD_BITS)
                                                 : CMD_COPY_BACK);
                    FUNC_FILL: wr_data = 32'(CMD_FILL);
                    default:   wr_data = 32'(CMD_INVERT);
                endcase
            end
            SLOT_TOKEN_LO: wr_data = token3_reg[31:0];
            SLOT_TOKEN_HI: wr_data = token3_reg[63:32];
            default:       wr_data = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Output register: holds each write for m_axis; m_axis_tready still gates the sequencer.
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (seq_fire) begin
            mv_reg <= 1'b1;
        end else if (m_axis_tready) begin
            mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (seq_fire) begin
            mdata_reg <= {wr_data, slot_offset(slot_reg)};
            mlast_reg <= wr_last;
        end
    end

    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = mdata_reg;
    assign m_axis_tlast  = mlast_reg;

endmodule

### sv/bcg_front.sv
`timescale 1ns / 1ps

// Input register, then the per-coordinate multiplies into a second register.
module bcg_front import bcg_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int IN_W = ((18 + 6 * COORD_BITS + 7) / 8) * 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  cfg_t            cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [IN_W-1:0] in_data,
    input  logic            in_first,
    input  logic            in_last,
    output logic            out_valid,
    input  logic            out_ready,
    output prim_t           out_prim
);

    localparam int CB   = COORD_BITS;
    localparam int XP_W = CB + 6;
    localparam int YP_W = CB + 16;

    logic          v1_reg;
    logic [1:0]    func1_reg;
    logic [CB-1:0] sx1_reg, sy1_reg, dx1_reg, dy1_reg, w1_reg, h1_reg;
    logic [15:0]   color1_reg;
    logic          first1_reg, last1_reg;

    logic          v2_reg;
    prim_t         prim2_reg;
    prim_t         prim2_next;

    logic          adv2;
    logic          in_fire;

    logic [XP_W-1:0] sx_prod, dx_prod;
    logic [YP_W-1:0] sy_prod, dy_prod, h_prod;

    assign adv2     = v1_reg && (!v2_reg || out_ready);
    assign in_ready = !v1_reg || !v2_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign out_valid = v2_reg;
    assign out_prim  = prim2_reg;

    always_comb begin
        sx_prod = XP_W'(sx1_reg) * XP_W'(cfg.depth);
        dx_prod = XP_W'(dx1_reg) * XP_W'(cfg.depth);
        sy_prod = YP_W'(sy1_reg) * YP_W'(cfg.pitch);
        dy_prod = YP_W'(dy1_reg) * YP_W'(cfg.pitch);
        h_prod  = YP_W'(h1_reg)  * YP_W'(cfg.pitch);

        prim2_next.func    = func1_reg;
        prim2_next.src_xb  = 32'(sx_prod >> 3);
        prim2_next.dst_xb  = 32'(dx_prod >> 3);
        prim2_next.src_yb  = 32'(sy_prod);
        prim2_next.dst_yb  = 32'(dy_prod);
        prim2_next.h_pitch = 32'(h_prod);
        if (cfg.depth == DEPTH_16BPP) begin
            prim2_next.width_f = 16'({w1_reg, 1'b1});
        end else begin
            prim2_next.width_f = 16'(w1_reg);
        end
        prim2_next.height_f = 16'(h1_reg);
        prim2_next.color    = color1_reg;
        prim2_next.first    = first1_reg;
        prim2_next.last     = last1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                v1_reg <= 1'b1;
            end else if (adv2) begin
                v1_reg <= 1'b0;
            end
            if (adv2) begin
                v2_reg <= 1'b1;
            end else if (out_ready) begin
                v2_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            func1_reg  <= in_data[1:0];
            sx1_reg    <= in_data[2 + 0*CB +: CB];
            sy1_reg    <= in_data[2 + 1*CB +: CB];
            dx1_reg    <= in_data[2 + 2*CB +: CB];
            dy1_reg    <= in_data[2 + 3*CB +: CB];
            w1_reg     <= in_data[2 + 4*CB +: CB];
            h1_reg     <= in_data[2 + 5*CB +: CB];
            color1_reg <= in_data[2 + 6*CB +: 16];
            first1_reg <= in_first;
            last1_reg  <= in_last;
        end
        if (adv2) begin
            prim2_reg <= prim2_next;
        end
    end

endmodule

### sv/bcg_checker.sv
`timescale 1ns / 1ps

module bcg_checker import bcg_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // Stalled write holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("write changed while stalled");

    // Output empties on reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("write valid after reset");

    // A primitive ends on its command write or on the high token half.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast |->
            m_axis_tdata[15:0] == OFS_CMD || m_axis_tdata[15:0] == OFS_TOKEN_HI)
        else $error("last write at wrong register");

    // Token halves go out back to back.
    a_token: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && m_axis_tdata[15:0] == OFS_TOKEN_LO |=>
            m_axis_tvalid && m_axis_tdata[15:0] == OFS_TOKEN_HI)
        else $error("token high half did not follow");

    // Source address write is followed at once by the destination write.
    a_dst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && m_axis_tdata[15:0] == OFS_SRC_ADDR |=>
            m_axis_tvalid && m_axis_tdata[15:0] == OFS_DST_ADDR)
        else $error("destination write did not follow");

endmodule

bind blit_command_generator bcg_checker u_bcg_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
